>>> rtl/trt_pkg.sv
// Package for the timed relay thermostat: phase type, register indexes,
// payload widths and the sensor-to-tenths conversion. No dependencies.
`default_nettype none

package trt_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ON     = 2'd1,
        PH_WAIT   = 2'd2,
        PH_FORCED = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_SETPOINT  = 3'd0,
        REG_HYST      = 3'd1,
        REG_ON_TIME   = 3'd2,
        REG_WAIT_TIME = 3'd3,
        REG_ALWAYS_ON = 3'd4,
        REG_ARMED     = 3'd5
    } reg_index_t;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TEMP_W     = 12;
    localparam int unsigned SECS_W     = 13;
    localparam int unsigned SET_W      = 14;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 32;
    localparam int unsigned OUT_USED_W = 1 + 2 + TEMP_W + SECS_W;

    // Reciprocal of ten for 16-bit operands: (x * 52429) >> 19 is exact.
    localparam logic [16:0] RECIP_TEN   = 17'd52429;
    localparam int unsigned RECIP_SHIFT = 19;

    // Sixteenths to rounded tenths (half up on the hundredths digit).
    typedef logic [3:0] tenth_t;
    localparam tenth_t FRAC_TENTHS [16] = '{
        4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd6, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9
    };

    // The rounded fraction never reaches ten, so no carry into the integer part.
    function automatic logic signed [TEMP_W-1:0] deci_from_raw(
        input logic signed [TEMP_W-1:0] raw
    );
        logic        neg;
        logic [11:0] mag;
        logic [7:0]  ip;
        logic [10:0] v;
        neg = raw[TEMP_W-1];
        mag = neg ? (12'd0 - raw) : raw;
        ip  = mag[11:4];
        v   = {ip, 3'b000} + {2'b00, ip, 1'b0} + {7'd0, FRAC_TENTHS[mag[3:0]]};
        return neg ? (12'sd0 - $signed({1'b0, v})) : $signed({1'b0, v});
    endfunction

    // Truncating divide by ten of a 16-bit duration into whole seconds.
    function automatic logic [SECS_W-1:0] secs_from_deci(input logic [TIME_W-1:0] deci);
        logic [32:0] prod;
        prod = {17'd0, deci} * {16'd0, RECIP_TEN};
        return prod[RECIP_SHIFT +: SECS_W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/timed_relay_thermostat_unit.sv
// Timed relay thermostat top level: tick stream in, one status item out per tick.
// Depends on trt_pkg for the phase type, register indexes and conversion.
`default_nettype none

// Throughput: one tick per cycle while s_tready is high; the phase, countdown and
// temperature update is a single pass of logic between the accepted item and the
// result register. A two-entry output (result register plus skid register) keeps
// s_tready high while one result waits. Reset (aresetn low, synchronous) clears
// all settings to zero, the temperature to zero, the phase to idle and both output
// entries.
module timed_relay_thermostat_unit
    import trt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // Configuration write port, no read-back.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

    // Tick stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // [11:0] raw_temp, rest zero
    input  wire logic                   s_tuser,   // [0] sample_valid

    // Status stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata    // [0] relay_on, [2:1] phase,
                                                   // [14:3] temp_deci,
                                                   // [27:15] seconds_left, rest zero
);

    // Settings. The seconds versions of the durations are divided at write
    // time, so the tick path sees only a mux of ready values.
    logic [SET_W-1:0]   setpoint_reg;
    logic [SET_W-1:0]   hyst_reg;
    logic               on_nz_reg;
    logic               wait_nz_reg;
    logic [SECS_W-1:0]  on_secs_reg;
    logic [SECS_W-1:0]  wait_secs_reg;
    logic               always_on_reg;
    logic               armed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg  <= '0;
            hyst_reg      <= '0;
            on_nz_reg     <= 1'b0;
            wait_nz_reg   <= 1'b0;
            on_secs_reg   <= '0;
            wait_secs_reg <= '0;
            always_on_reg <= 1'b0;
            armed_reg     <= 1'b0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_addr))
                REG_SETPOINT:  setpoint_reg <= cfg_wdata[SET_W-1:0];
                REG_HYST:      hyst_reg     <= cfg_wdata[SET_W-1:0];
                REG_ON_TIME: begin
                    on_nz_reg   <= (cfg_wdata != '0);
                    on_secs_reg <= secs_from_deci(cfg_wdata[TIME_W-1:0]);
                end
                REG_WAIT_TIME: begin
                    wait_nz_reg   <= (cfg_wdata != '0);
                    wait_secs_reg <= secs_from_deci(cfg_wdata[TIME_W-1:0]);
                end
                REG_ALWAYS_ON: always_on_reg <= cfg_wdata[0];
                REG_ARMED:     armed_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Handshake: a tick is taken whenever the skid entry is free.
    logic in_fire;
    logic out_fire;
    logic out_valid_reg;
    logic skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;

    // Controller state.
    phase_t                    phase_reg, phase_next;
    logic [SECS_W-1:0]         count_reg, count_next;
    logic signed [TEMP_W-1:0]  temp_reg, temp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            temp_reg  <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            temp_reg  <= temp_next;
        end
    end

    // Cut-in limit, setpoint minus hysteresis, as a 15-bit signed value.
    logic signed [SET_W:0]   limit;
    logic                    settings_ok;
    logic                    cold;
    logic [SECS_W-1:0]       count_dec;

    // A tick with a new sample replaces the stored temperature before the
    // program compares it against the cut-in limit.
    assign temp_next   = s_tuser ? deci_from_raw(s_tdata[TEMP_W-1:0]) : temp_reg;
    assign limit       = $signed({1'b0, setpoint_reg}) - $signed({1'b0, hyst_reg});
    assign settings_ok = armed_reg && (setpoint_reg != '0) && (hyst_reg != '0)
                         && on_nz_reg && wait_nz_reg;
    assign cold        = ($signed({{(SET_W + 1 - TEMP_W){temp_next[TEMP_W-1]}}, temp_next})
                          <= limit);
    assign count_dec   = (count_reg != '0) ? (count_reg - 1'b1) : count_reg;

    always_comb begin
        phase_next = phase_reg;
        count_next = '0;

        // Countdown of a timed phase; the countdown makes at most one phase change per tick.
        unique case (phase_reg)
            PH_ON: begin
                count_next = count_dec;
                if (count_dec == '0) begin
                    phase_next = PH_WAIT;
                    count_next = wait_secs_reg;
                end
            end
            PH_WAIT: begin
                count_next = count_dec;
                if (count_dec == '0) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_IDLE, PH_FORCED: count_next = '0;
            default: count_next = '0;
        endcase

        // Forced operation overrides the program; leaving it returns to idle
        // before the program gets its chance on the same tick.
        if (always_on_reg) begin
            phase_next = PH_FORCED;
            count_next = '0;
        end else begin
            if (phase_next == PH_FORCED) begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
            if (settings_ok && (phase_next == PH_IDLE) && cold) begin
                phase_next = PH_ON;
                count_next = on_secs_reg;
            end
        end
    end

    // Result item built from the state after this tick.
    logic [OUT_DATA_W-1:0] result;
    logic                  relay_next;

    assign relay_next = (phase_next == PH_ON) || (phase_next == PH_FORCED);
    assign result     = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                         count_next, temp_next, phase_next, relay_next};

    // Result register with a skid entry behind it.
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_fire) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else if (!in_fire) begin
                    out_valid_reg <= 1'b0;
                end
            end
            if (in_fire) begin
                if (out_valid_reg && !m_tready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_fire && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else if (in_fire && !(out_valid_reg && !m_tready)) begin
            out_data_reg <= result;
        end
        if (in_fire && out_valid_reg && !m_tready) begin
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> sim/timed_relay_thermostat_unit_tb.sv
// Self-checking testbench for the timed relay thermostat unit.
// Holds a scoreboard class with its own thermostat predictor; depends on trt_pkg
// and timed_relay_thermostat_unit only.
`timescale 1ns / 1ps

module timed_relay_thermostat_unit_tb;
    import trt_pkg::*;

    // One status item as the block reports it after a tick.
    typedef struct packed {
        logic               relay;
        phase_t             phase;
        logic signed [11:0] temp;
        logic [12:0]        secs;
    } status_t;

    // The scoreboard keeps a private copy of the settings and of the phase
    // machine, predicts the status of every accepted tick and compares each
    // status item that leaves the block against the oldest prediction.
    class thermostat_scoreboard;
        logic [13:0]        setpoint = '0;
        logic [13:0]        hyst     = '0;
        logic [15:0]        on_time  = '0;
        logic [15:0]        wait_time = '0;
        logic               forced   = 1'b0;
        logic               armed    = 1'b0;
        logic signed [11:0] temp     = '0;
        phase_t             phase    = PH_IDLE;
        logic [12:0]        countdown = '0;
        status_t            expected_status[$];
        int                 errors   = 0;

        function void set_reg(reg_index_t idx, logic [15:0] value);
            case (idx)
                REG_SETPOINT:  setpoint  = value[13:0];
                REG_HYST:      hyst      = value[13:0];
                REG_ON_TIME:   on_time   = value;
                REG_WAIT_TIME: wait_time = value;
                REG_ALWAYS_ON: forced    = value[0];
                REG_ARMED:     armed     = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        // Sixteenths of a degree to tenths, rounding the fraction of the
        // magnitude half up and applying the sign afterwards.
        function logic signed [11:0] tenths_from_raw(logic [11:0] raw);
            bit neg;
            int mag;
            int fr;
            int ip;
            int v;
            neg = raw[11];
            mag = neg ? 4096 - int'(raw) : int'(raw);
            fr  = ((mag % 16) * 100) / 16;
            ip  = mag / 16;
            if (fr % 10 >= 5) fr += 10;
            fr = fr / 10;
            if (fr == 10) begin
                ip += 1;
                fr = 0;
            end
            v = ip * 10 + fr;
            return neg ? 12'(-v) : 12'(v);
        endfunction

        function void predict_status(bit sample, logic [11:0] raw);
            status_t st;
            int      limit;
            if (sample) temp = tenths_from_raw(raw);
            if (phase == PH_ON || phase == PH_WAIT) begin
                if (countdown != 0) countdown = countdown - 1'b1;
                if (countdown == 0) begin
                    if (phase == PH_ON) begin
                        phase = PH_WAIT;
                        countdown = 13'(wait_time / 10);
                    end else begin
                        phase = PH_IDLE;
                    end
                end
            end else begin
                countdown = '0;
            end
            if (forced) begin
                phase = PH_FORCED;
                countdown = '0;
            end else begin
                if (phase == PH_FORCED) begin
                    phase = PH_IDLE;
                    countdown = '0;
                end
                limit = int'(setpoint) - int'(hyst);
                if (armed && setpoint != 0 && hyst != 0 && on_time != 0 && wait_time != 0
                    && phase == PH_IDLE && int'(temp) <= limit) begin
                    phase = PH_ON;
                    countdown = 13'(on_time / 10);
                end
            end
            st.relay = (phase == PH_ON || phase == PH_FORCED);
            st.phase = phase;
            st.temp  = temp;
            st.secs  = countdown;
            expected_status.push_back(st);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_status(logic [31:0] d);
            status_t want;
            status_t got;
            if (expected_status.size() == 0) begin
                report_mismatch("status item with no tick pending");
                return;
            end
            want = expected_status.pop_front();
            got.relay = d[0];
            got.phase = phase_t'(d[2:1]);
            got.temp  = d[14:3];
            got.secs  = d[27:15];
            if (got.relay !== want.relay)
                report_mismatch($sformatf("relay_on %0b, wanted %0b", got.relay, want.relay));
            if (got.phase !== want.phase)
                report_mismatch($sformatf("phase %s, wanted %s",
                                          got.phase.name(), want.phase.name()));
            if (got.temp !== want.temp)
                report_mismatch($sformatf("temp_deci %0d, wanted %0d", got.temp, want.temp));
            if (got.secs !== want.secs)
                report_mismatch($sformatf("seconds_left %0d, wanted %0d",
                                          got.secs, want.secs));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 36;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [11:0] raw_temp, rest zero
    logic                  s_tuser;   // [0] sample_valid
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // [0] relay_on, [2:1] phase, [14:3] temp_deci,
                                      // [27:15] seconds_left, rest zero

    // While set, neither side idles; one run of phases in the random part uses it.
    bit no_idle = 1'b0;
    int cycle_count;

    thermostat_scoreboard sb;

    timed_relay_thermostat_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Sampling happens at the rising edge, where everything the testbench
    // drives has been stable since the falling edge. A status item leaving
    // the block is always older than a tick entering in the same cycle, so
    // checking first and predicting second keeps the queue in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_status(m_tdata);
            if (s_tvalid && s_tready) sb.predict_status(s_tuser, s_tdata[11:0]);
        end
    end

    // The receiver stalls at random except during the quiet stretch.
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Offers one tick, with random gaps in front of it, and returns once
    // the block has taken it. Every change happens at a falling edge and
    // each falling edge assigns s_tvalid once, so a held valid never dips.
    task automatic send_tick(input bit sample, input logic [11:0] raw);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= sample;
        s_tdata  <= {4'd0, raw};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering ticks and waits until every predicted status item has
    // come out. Every tick yields a status item, so an empty queue means the
    // block is idle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        sb.set_reg(idx, value);
    endtask

    // Writes all six registers back to back while the block is idle.
    task automatic apply_settings(input logic [13:0] sp, input logic [13:0] hy,
                                  input logic [15:0] on_t, input logic [15:0] wt,
                                  input bit ao, input bit arm);
        drain();
        write_reg(REG_SETPOINT, {2'b00, sp});
        write_reg(REG_HYST, {2'b00, hy});
        write_reg(REG_ON_TIME, on_t);
        write_reg(REG_WAIT_TIME, wt);
        write_reg(REG_ALWAYS_ON, {15'd0, ao});
        write_reg(REG_ARMED, {15'd0, arm});
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          sent;
        int          phase_idx;
        int          n;
        int          center;
        int          raw_i;
        bit          noise;
        logic [13:0] sp;
        logic [13:0] hy;
        logic [15:0] on_t;
        logic [15:0] wt;
        bit          ao;
        bit          arm;

        sb = new;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Conversion corners with the reset settings (program off): both
        // ends of the reading range, the most negative reading among them,
        // half-way fractions on both signs, and a tick without a sample.
        send_tick(1'b1, 12'h800);
        send_tick(1'b1, 12'h7FF);
        send_tick(1'b1, 12'h000);
        send_tick(1'b1, 12'hFFF);
        send_tick(1'b1, 12'h001);
        send_tick(1'b1, 12'h008);
        send_tick(1'b1, 12'hFF8);
        send_tick(1'b0, 12'h555);
        send_tick(1'b1, 12'h00F);
        send_tick(1'b1, 12'hFF1);

        // Forced on, then released: the block must drop back to idle before
        // the program check starts a two-second on phase and a one-second wait.
        apply_settings(14'd200, 14'd10, 16'd25, 16'd15, 1'b1, 1'b1);
        send_tick(1'b1, 12'h010);
        send_tick(1'b0, 12'h000);
        apply_settings(14'd200, 14'd10, 16'd25, 16'd15, 1'b0, 1'b1);
        repeat (6) send_tick(1'b0, 12'h000);

        // Durations below one second: both phases end on the very next tick.
        apply_settings(14'd200, 14'd10, 16'd5, 16'd9, 1'b0, 1'b1);
        repeat (4) send_tick(1'b0, 12'h000);

        // Largest settings: limit of zero, the longest on phase, then force
        // it on and release it with a limit far below the coldest reading.
        apply_settings(14'd9999, 14'd9999, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        send_tick(1'b1, 12'h800);
        send_tick(1'b0, 12'h000);
        apply_settings(14'd1, 14'd9999, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_tick(1'b1, 12'h800);
        apply_settings(14'd1, 14'd9999, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        send_tick(1'b1, 12'h800);
        send_tick(1'b0, 12'h7FF);

        // Random phases. Most are armed with usable settings, short durations
        // and readings scattered around the cut-in limit so that the relay
        // cycles through on, wait and idle. About one in five is noise with
        // settings that may be zero, large hysteresis and random force and arm bits.
        sent = 0;
        phase_idx = 0;
        while (sent < 500) begin
            noise = ($urandom_range(4) == 0);
            if (noise) begin
                sp   = ($urandom_range(3) == 0) ? 14'd0 : 14'($urandom_range(9999));
                hy   = ($urandom_range(3) == 0) ? 14'd0 : 14'($urandom_range(9999));
                on_t = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(300));
                wt   = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(300));
                ao   = 1'($urandom_range(1));
                arm  = 1'($urandom_range(1));
            end else begin
                sp   = 14'($urandom_range(1300, 1));
                hy   = 14'($urandom_range(60, 1));
                on_t = 16'($urandom_range(80, 1));
                wt   = 16'($urandom_range(80, 1));
                ao   = ($urandom_range(9) == 0);
                arm  = 1'b1;
            end
            apply_settings(sp, hy, on_t, wt, ao, arm);
            no_idle = (phase_idx >= 4 && phase_idx < 8);
            center = ((int'(sp) - int'(hy)) * 16) / 10;
            n = $urandom_range(40, 10);
            repeat (n) begin
                if (noise || $urandom_range(4) == 0)
                    raw_i = int'($urandom_range(4095)) - 2048;
                else
                    raw_i = center + int'($urandom_range(400)) - 200;
                if (raw_i > 2047) raw_i = 2047;
                if (raw_i < -2048) raw_i = -2048;
                send_tick($urandom_range(9) < 7, raw_i[11:0]);
            end
            sent += n;
            phase_idx++;
        end

        no_idle = 1'b0;
        drain();
        repeat (4) @(posedge aclk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
